[rtl/core/ssseq_pkg.sv]
// Shared types, mode codes and delay table of the strobe shutdown sequencer.
`default_nettype none
package ssseq_pkg;

  localparam int unsigned InWidth   = 16;
  localparam int unsigned OutWidth  = 8;

  localparam logic [2:0] ModeInit  = 3'd0;
  localparam logic [2:0] ModeWStop = 3'd1;
  localparam logic [2:0] ModeWPOff = 3'd2;
  localparam logic [2:0] ModeDelay = 3'd3;
  localparam logic [2:0] ModeError = 3'd4;
  localparam logic [2:0] ModeOff   = 3'd5;

  localparam logic [7:0] HbLimitReset = 8'd50;

  typedef struct packed {
    logic [2:0] rotary_pins;
    logic       seconds_mode;
    logic       fault_check_off;
    logic       strobe_ok;
    logic       stop_detect;
    logic       power_present;
    logic       tick;
  } in_word_t;

  typedef struct packed {
    logic [2:0] mode_code;
    logic       led_red;
    logic       led_green;
    logic       power_hold;
    logic       strobe_on;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  mode_before_error;
    logic [7:0]  hb_count;
    logic [15:0] sd_count;
    logic [2:0]  rotary;
    logic        strobe;
    logic        hold;
    logic        green;
    logic        red;
  } seq_state_t;

  function automatic logic [15:0] delay_limit(input logic [3:0] idx);
    logic [15:0] v;
    unique case (idx)
      4'd0:    v = 16'd0;
      4'd1:    v = 16'd600;
      4'd2:    v = 16'd840;
      4'd3:    v = 16'd1080;
      4'd4:    v = 16'd1320;
      4'd5:    v = 16'd1560;
      4'd6:    v = 16'd1800;
      4'd7:    v = 16'd2400;
      4'd8:    v = 16'd0;
      4'd9:    v = 16'd10;
      4'd10:   v = 16'd14;
      4'd11:   v = 16'd18;
      4'd12:   v = 16'd22;
      4'd13:   v = 16'd26;
      4'd14:   v = 16'd30;
      default: v = 16'd40;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/core/ssseq_next.sv]
// Next-state logic for one pass of the sequencer loop.
`default_nettype none
module ssseq_next (
  input  ssseq_pkg::seq_state_t cur_i,
  input  ssseq_pkg::in_word_t   word_i,
  input  logic [7:0]            hb_limit_i,
  output ssseq_pkg::seq_state_t nxt_o
);

  ssseq_pkg::seq_state_t s;
  logic [7:0]            hb;

  always_comb begin
    s  = cur_i;
    hb = cur_i.hb_count + {7'd0, word_i.tick};
    if (cur_i.mode != ssseq_pkg::ModeOff) begin
      s.hb_count = hb;
      if (hb > hb_limit_i) begin
        s.hb_count = 8'd0;
        s.green    = ~cur_i.green;
        s.sd_count = cur_i.sd_count + 16'd1;
        s.rotary   = ~word_i.rotary_pins;
      end
      unique case (cur_i.mode)
        ssseq_pkg::ModeInit: begin
          s.mode   = ssseq_pkg::ModeWStop;
          s.strobe = 1'b1;
        end
        ssseq_pkg::ModeWStop: begin
          if (word_i.stop_detect) begin
            s.mode   = ssseq_pkg::ModeWPOff;
            s.strobe = 1'b0;
          end
          if (!word_i.strobe_ok && !word_i.fault_check_off) begin
            s.mode_before_error = s.mode;
            s.mode              = ssseq_pkg::ModeError;
          end
          if (!word_i.power_present) begin
            s.sd_count = 16'd0;
            s.mode     = ssseq_pkg::ModeDelay;
            s.strobe   = 1'b1;
          end
        end
        ssseq_pkg::ModeWPOff: begin
          if (!word_i.power_present) begin
            s.sd_count = 16'd0;
            s.mode     = ssseq_pkg::ModeDelay;
            s.strobe   = 1'b1;
          end
        end
        ssseq_pkg::ModeDelay: begin
          if (s.sd_count > ssseq_pkg::delay_limit({word_i.seconds_mode, s.rotary})) begin
            s.hold = 1'b0;
            s.mode = ssseq_pkg::ModeOff;
          end else if (word_i.power_present && (s.sd_count > 16'd2)) begin
            s.mode = ssseq_pkg::ModeInit;
          end
        end
        ssseq_pkg::ModeError: begin
          s.red = 1'b1;
          if (word_i.strobe_ok) begin
            s.red = 1'b0;
            if (cur_i.mode_before_error == ssseq_pkg::ModeWStop) begin
              s.mode = ssseq_pkg::ModeWStop;
            end
          end
        end
        ssseq_pkg::ModeOff: begin
          s = cur_i;
        end
        default: begin
          s.mode = ssseq_pkg::ModeInit;
        end
      endcase
    end
  end

  assign nxt_o = s;

endmodule
`default_nettype wire

[rtl/core/strobe_shutdown_sequencer_unit.sv]
// Top level of the strobe shutdown sequencer: input register, state and result register.
`default_nettype none
// One input word is one pass of the control loop; it yields exactly one result word
// with the levels after that pass. A taken word waits in the input register; its result
// word enters the result register once the output side has room. One word is taken
// every cycle while the output side keeps up (the next sequencer state is combinational).
// The user writes the heartbeat limit through cfg_we_i only while no word is in flight;
// the block itself does not enforce this. The limit resets to 50.
module strobe_shutdown_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tick, power_present, stop_detect, strobe_ok, fault_check_off, seconds_mode,
  // rotary_pins[2:0], zero fill
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // strobe_on, power_hold, led_green, led_red, mode_code[2:0], zero fill
  output logic [7:0]  m_axis_tdata
);

  logic                  in_valid_q;
  ssseq_pkg::in_word_t   in_word_q;
  logic                  out_valid_q;
  ssseq_pkg::out_word_t  out_word_q;
  logic [7:0]            hb_limit_q;
  ssseq_pkg::seq_state_t state_q;
  ssseq_pkg::seq_state_t state_d;
  logic                  advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  ssseq_next u_next (
    .cur_i      (state_q),
    .word_i     (in_word_q),
    .hb_limit_i (hb_limit_q),
    .nxt_o      (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_limit_q <= ssseq_pkg::HbLimitReset;
    end else if (cfg_we_i) begin
      hb_limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{mode: ssseq_pkg::ModeInit, mode_before_error: 3'd0,
                       hb_count: 8'd0, sd_count: 16'd0, rotary: 3'd0,
                       strobe: 1'b0, hold: 1'b1, green: 1'b0, red: 1'b0};
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q <= s_axis_tdata[8:0];
    end
    if (advance) begin
      out_word_q <= '{mode_code: state_d.mode, led_red: state_d.red,
                      led_green: state_d.green, power_hold: state_d.hold,
                      strobe_on: state_d.strobe};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_word_q};

endmodule
`default_nettype wire
